// File: hdl/kpl_pkg.sv
`timescale 1ns / 1ps
// Kerning pair lookup: shared types, codes and defaults.
package kpl_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 1024;

	localparam int CODE_W  = 16;
	localparam int KERN_W  = 8;
	localparam int PIDX_W  = 8;
	localparam int ADDR_W  = 10;
	localparam int COUNT_W = 8;
	localparam int TOTAL_W = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = TOTAL_W;

	// command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PER_GLYPH_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ENTRIES  = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic [ADDR_W-1:0]        entry_addr;
		logic [CODE_W-1:0]        entry_code;
		logic signed [KERN_W-1:0] entry_kern;
		logic [PIDX_W-1:0]        entry_pair_index;
		logic [CODE_W-1:0]        glyph_code;
		logic [ADDR_W-1:0]        glyph_start;
		logic [COUNT_W-1:0]       glyph_count;
		logic [CODE_W-1:0]        next_code;
	} kpl_req_t;

	typedef struct packed {
		logic signed [KERN_W-1:0] kern_value;
		logic                     found;
	} kpl_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} kpl_state_t;

endpackage

// File: hdl/kpl_if.sv
`timescale 1ns / 1ps
// Kerning pair lookup: request and response channel interfaces.
interface kpl_req_if;
	logic              valid;
	logic              ready;
	kpl_pkg::kpl_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface kpl_rsp_if;
	logic              valid;
	logic              ready;
	kpl_pkg::kpl_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/kerning_pair_lookup.sv
`timescale 1ns / 1ps
// Kerning pair lookup: entry table in block memory with a sequential scan engine.
//
// Channels: req carries one beat per command. A write beat (cmd = write) stores one
// entry; it yields no response. A lookup beat starts a scan and yields exactly one
// rsp beat with kern_value and found.
// Config: cfg_we/cfg_index/cfg_data write per_glyph_mode (0) and total_entries (1);
// write them only while no lookup is in flight.
// Throughput: one table entry per cycle through the single memory read port and a
// single compare unit. A lookup scans N slots (N <= glyph_count in per-glyph mode,
// <= total_entries in pair mode) and stops at the first hit. A zero count or an
// empty scan window ends without a read and answers with found low. req.ready is
// low while a lookup is running.
// Reset: arst_n clears the sequencer, config registers and response valid. Table
// contents are not cleared; slots read before being written return garbage.
// Stall: the response sits in an output register. While rsp is stalled new writes
// and a new lookup are still accepted; a lookup that finishes before the held beat
// is taken waits in its done state with req.ready low.
module kerning_pair_lookup #(
	parameter int unsigned TABLE_DEPTH = kpl_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [kpl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kpl_pkg::CFG_DATA_W-1:0]      cfg_data,
	kpl_req_if.sink                             req,
	kpl_rsp_if.source                           rsp
);
	import kpl_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	// slot counter must hold start + count and the depth itself
	localparam int CW = (AW + 1 > ADDR_W + 1) ? AW + 1 : ADDR_W + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// config
	logic               mode_pg_q;
	logic [TOTAL_W-1:0] total_q;

	// sequencer
	kpl_state_t state_q, state_d;
	logic [CW-1:0]     slot_q, end_q;
	logic [CODE_W-1:0] next_q;
	logic [PIDX_W-1:0] gcode_lo_q;
	logic              pair_ok_q;   // glyph code fits the index byte
	logic              scan_pg_q;   // mode latched for this lookup
	logic              rd_pend_q;
	logic [31:0]       rd_data_q;
	logic              res_hit_q;
	logic [KERN_W-1:0] res_kern_q;

	// output register
	logic              out_valid_q;
	kpl_rsp_t          out_q;

	logic [31:0] kern_mem [TABLE_DEPTH];

	logic req_fire, wr_en, issue, match, scan_end, out_free;
	logic [CW-1:0] sum_w, pg_end_w, tot_w, pr_end_w;

	assign req_fire = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	// entries past the table are dropped
	assign wr_en = req_fire && (req.data.cmd == CMD_WRITE)
		&& (32'(req.data.entry_addr) < TABLE_DEPTH);

	// scan window, clipped to the table end
	assign sum_w    = CW'(req.data.glyph_start) + CW'(req.data.glyph_count);
	assign pg_end_w = (sum_w > DEPTH_C) ? DEPTH_C : sum_w;
	assign tot_w    = CW'(total_q);
	assign pr_end_w = (tot_w > DEPTH_C) ? DEPTH_C : tot_w;

	// shared compare on the registered read word
	assign match = rd_pend_q && (rd_data_q[15:0] == next_q)
		&& (scan_pg_q || (pair_ok_q && rd_data_q[31:24] == gcode_lo_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_pg_q <= 1'b0;
			total_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PER_GLYPH_MODE: mode_pg_q <= cfg_data[0];
				REG_TOTAL_ENTRIES:  total_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			kern_mem[AW'(req.data.entry_addr)] <= {req.data.entry_pair_index,
				req.data.entry_kern, req.data.entry_code};
		if (issue)
			rd_data_q <= kern_mem[slot_q[AW-1:0]];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && req.data.cmd == CMD_LOOKUP)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (match || scan_end)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		scan_end  = 1'b0;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SCAN: begin
				issue    = (slot_q < end_q) && !match;
				scan_end = (slot_q >= end_q) && !rd_pend_q;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_pend_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= issue;
		end
	end

	// scan context and result, no reset needed
	always_ff @(posedge clk) begin
		if (req_fire && req.data.cmd == CMD_LOOKUP) begin
			next_q     <= req.data.next_code;
			gcode_lo_q <= req.data.glyph_code[PIDX_W-1:0];
			pair_ok_q  <= (req.data.glyph_code[CODE_W-1:PIDX_W] == '0);
			scan_pg_q  <= mode_pg_q;
			res_hit_q  <= 1'b0;
			res_kern_q <= '0;
			if (req.data.glyph_count == '0) begin
				slot_q <= '0;
				end_q  <= '0;
			end else if (mode_pg_q) begin
				slot_q <= CW'(req.data.glyph_start);
				end_q  <= pg_end_w;
			end else begin
				slot_q <= '0;
				end_q  <= pr_end_w;
			end
		end else if (state_q == ST_SCAN) begin
			if (issue)
				slot_q <= slot_q + 1'b1;
			if (match) begin
				res_hit_q  <= 1'b1;
				res_kern_q <= rd_data_q[23:16];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q.kern_value <= res_kern_q;
			out_q.found      <= res_hit_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

`ifndef SYNTH
	a_slot_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> slot_q <= end_q && end_q <= DEPTH_C)
		else $error("scan slot outside window");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> $past(state_q) == ST_SCAN)
		else $error("read data pending outside scan");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.found |-> rsp.data.kern_value == '0)
		else $error("miss with nonzero kern");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> rsp.valid && state_q == ST_IDLE)
		else $error("finished lookup not presented");
`endif

endmodule
